// ===== hdl/srb_pkg.sv =====
`timescale 1ns / 1ps

package srb_pkg;

    // Width of the slot index field carried on the result channel.
    localparam int SLOT_FIELD_W = 4;

    // One segment header as it arrives.
    typedef struct packed {
        logic [31:0] seq_number;
        logic [10:0] seg_length;
    } t_in_item;

    // One result: a released segment or the closing acknowledgement.
    typedef struct packed {
        logic                    kind;
        logic [31:0]             out_seq;
        logic [10:0]             out_length;
        logic [SLOT_FIELD_W-1:0] slot_index;
        logic [31:0]             ack_value;
        logic                    eof_seen;
        logic                    last;
    } t_out_item;

    // Result kinds.
    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    // Contents of one ring slot.
    typedef struct packed {
        logic [31:0] seq;
        logic [10:0] len;
    } t_slot_entry;

    // Handshake between the controller and the slot divider.
    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_WRITE,
        ST_READ,
        ST_CHECK,
        ST_RELEASE,
        ST_ACK
    } t_srb_state;

endpackage

// ===== hdl/srb_slot_mem.sv =====
`timescale 1ns / 1ps

module srb_slot_mem
    import srb_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_slot_entry   i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_slot_entry   o_rd_data
);

    t_slot_entry r_mem [DEPTH];
    t_slot_entry r_rd_data;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Single read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/srb_div.sv =====
`timescale 1ns / 1ps

module srb_div
    import srb_pkg::*;
#(
    parameter int SEGMENT_BYTES = 1456,
    parameter int QW            = 4,
    parameter int DW            = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    output logic          o_done,
    output logic [QW-1:0] o_quotient
);

    // Reciprocal of the segment size, exact for every dividend below 2**DW.
    localparam int            LW    = (SEGMENT_BYTES > 1) ? $clog2(SEGMENT_BYTES) : 0;
    localparam int            SH    = DW + LW;
    localparam int            MW    = DW + 1;
    localparam int            PW    = DW + MW;
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SH) + 64'(SEGMENT_BYTES) - 64'd1)
                                          / 64'(SEGMENT_BYTES));

    logic          r_busy;
    logic          r_done;
    logic [DW-1:0] r_dividend;
    logic [QW-1:0] r_q;

    logic [PW-1:0] w_product;

    // The quotient sits in the product bits above the reciprocal shift.
    assign w_product = {{MW{1'b0}}, r_dividend} * {{DW{1'b0}}, RECIP};

    // The dividend is captured on start and multiplied in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    // Dividend and quotient registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dividend <= i_dividend;
        end
        if (r_busy) begin
            r_q <= w_product[SH +: QW];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ===== hdl/segment_reorder_buffer.sv =====
`timescale 1ns / 1ps

// Reorder buffer for a selective-repeat receiver.
// The input channel (i_in_valid, o_in_stall, i_in_data) carries one segment
// header per transaction: a byte sequence number and a payload length.
// The output channel (o_out_valid, i_out_stall, o_out_data) returns, for each
// header, zero or more released in-order segments followed by one
// acknowledgement that has last set. A zero-length segment at the expected
// sequence marks end of file; after it every header only gets acknowledged.
// One header is processed at a time. A header in the window passes the slot
// divider, which registers the offset and then multiplies it by the
// reciprocal of the segment size, then the slot write, the read and check of
// the ring start, the acknowledgement load and the return to idle before the
// next header can be taken. Each released segment adds another
// read-check-release walk of the memory. Headers outside the window or behind
// the expected sequence skip the divider and the slot write, and after end of
// file a header goes straight to the acknowledgement.
// A stalled receiver holds the result in the output register; the next
// header is still taken while the closing acknowledgement waits there.
// Synchronous reset clears the expected sequence, the ring start, all slot
// valid bits and the end-of-file flag; no clearing pass is needed.

module segment_reorder_buffer
    import srb_pkg::*;
#(
    parameter int RING_SLOTS    = 16,
    parameter int SEGMENT_BYTES = 1456
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int SW    = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int WIN   = RING_SLOTS * SEGMENT_BYTES;
    localparam int WIN_W = $clog2(WIN + 1);

    t_srb_state r_state;
    t_srb_state n_state;

    logic [31:0]           r_expected;
    logic [SW-1:0]         r_ring_start;
    logic [RING_SLOTS-1:0] r_valid;
    logic                  r_done;
    logic [31:0]           r_seq;
    logic [10:0]           r_len;
    logic                  r_out_valid;
    t_out_item             r_out;

    t_div_ctl      w_div;
    logic [SW-1:0] w_quot;
    t_slot_entry   w_rd_data;
    logic          w_in_acc;
    logic [31:0]   w_offset;
    logic          w_in_win;
    logic [SW:0]   w_slot_sum;
    logic [SW-1:0] w_slot;
    logic [SW:0]   w_next_sum;
    logic [SW-1:0] w_next_start;
    logic          w_hit;
    logic          w_out_free;
    logic          w_mem_wr;
    logic          w_mem_rd;
    logic          w_load_rel;
    logic          w_load_ack;
    logic [31:0]   w_start_ext;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Offset to the expected sequence and the window test.
    assign w_offset = i_in_data.seq_number - r_expected;
    assign w_in_win = !w_offset[31] && (w_offset < 32'(WIN));

    // Target slot, counted from the ring start.
    assign w_slot_sum = {1'b0, r_ring_start} + {1'b0, w_quot};
    assign w_slot     = (w_slot_sum >= (SW+1)'(RING_SLOTS)) ?
                        SW'(w_slot_sum - (SW+1)'(RING_SLOTS)) : w_slot_sum[SW-1:0];

    // Ring start after a release.
    assign w_next_sum   = {1'b0, r_ring_start} + (SW+1)'(1);
    assign w_next_start = (w_next_sum >= (SW+1)'(RING_SLOTS)) ?
                          '0 : w_next_sum[SW-1:0];

    // Hit: the slot at the ring start is valid and holds the expected segment.
    assign w_hit = r_valid[r_ring_start] && (w_rd_data.seq == r_expected);

    assign w_start_ext = 32'(r_ring_start);

    srb_div #(
        .SEGMENT_BYTES(SEGMENT_BYTES),
        .QW           (SW),
        .DW           (WIN_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div.start),
        .i_dividend(w_offset[WIN_W-1:0]),
        .o_done    (w_div.done),
        .o_quotient(w_quot)
    );

    srb_slot_mem #(
        .DEPTH(RING_SLOTS),
        .AW   (SW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_wr_en  (w_mem_wr),
        .i_wr_addr(w_slot),
        .i_wr_data({r_seq, r_len}),
        .i_rd_en  (w_mem_rd),
        .i_rd_addr(r_ring_start),
        .o_rd_data(w_rd_data)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    priority if (r_done) begin
                        n_state = ST_ACK;
                    end else if (w_in_win) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_DIV: begin
                if (w_div.done) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (w_hit && (w_rd_data.len != '0)) begin
                    n_state = ST_RELEASE;
                end else begin
                    n_state = ST_ACK;
                end
            end
            ST_RELEASE: begin
                if (w_out_free) begin
                    n_state = ST_READ;
                end
            end
            ST_ACK: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the state machine.
    always_comb begin
        o_in_stall  = 1'b1;
        w_div.start = 1'b0;
        w_mem_wr    = 1'b0;
        w_mem_rd    = 1'b0;
        w_load_rel  = 1'b0;
        w_load_ack  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall  = 1'b0;
                w_div.start = i_in_valid && !r_done && w_in_win;
            end
            ST_WRITE: begin
                w_mem_wr = 1'b1;
            end
            ST_READ: begin
                w_mem_rd = 1'b1;
            end
            ST_RELEASE: begin
                w_load_rel = w_out_free;
            end
            ST_ACK: begin
                w_load_ack = w_out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // State register and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_expected   <= '0;
            r_ring_start <= '0;
            r_valid      <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_mem_wr) begin
                r_valid[w_slot] <= 1'b1;
            end
            if ((r_state == ST_CHECK) && w_hit) begin
                r_valid[r_ring_start] <= 1'b0;
                r_expected <= r_expected + 32'(w_rd_data.len);
                if (w_rd_data.len == '0) begin
                    r_done <= 1'b1;
                end
            end
            if (w_load_rel) begin
                r_ring_start <= w_next_start;
            end
        end
    end

    // Header capture.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_seq <= i_in_data.seq_number;
            r_len <= i_in_data.seg_length;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_rel || w_load_ack) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_rel) begin
            r_out.kind       <= KIND_RELEASE;
            r_out.out_seq    <= w_rd_data.seq;
            r_out.out_length <= w_rd_data.len;
            r_out.slot_index <= w_start_ext[SLOT_FIELD_W-1:0];
            r_out.ack_value  <= r_expected;
            r_out.eof_seen   <= 1'b0;
            r_out.last       <= 1'b0;
        end else if (w_load_ack) begin
            r_out.kind       <= KIND_ACK;
            r_out.out_seq    <= '0;
            r_out.out_length <= '0;
            r_out.slot_index <= '0;
            r_out.ack_value  <= r_expected;
            r_out.eof_seen   <= r_done;
            r_out.last       <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // End of file, once seen, stays until reset.
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("end-of-file flag cleared");

    // A released segment never closes the item.
    a_release_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.kind == KIND_RELEASE)) |->
        (!o_out_data.last && !o_out_data.eof_seen))
        else $error("release result marked last");

    // The ring start stays inside the ring.
    a_ring_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ring_start) < 32'(RING_SLOTS))
        else $error("ring start out of range");

    // The divider finishes only while the controller waits for it.
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == ST_DIV))
        else $error("divider finished outside its state");

    // The computed slot offset is always inside the ring.
    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (32'(w_quot) < 32'(RING_SLOTS)))
        else $error("slot offset beyond the ring");
`endif

endmodule
